// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker modules of this project.
// Each macro clocks on the given clock and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// Next-cycle implication, checked on every rising edge out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

// ===== rtl/core/arb_pkg.sv =====
// Shared types, constants and register indexes for the affine rectangle bounds block.
// No dependencies; every other file of the block refers to it by scoped names.
package arb_pkg;

  localparam int unsigned CoordW = 16;               // pixel coordinate width
  localparam int unsigned CoefW  = 32;               // Q15.16 register width
  localparam int unsigned FracW  = 16;               // fraction bits
  localparam int unsigned ProdW  = CoefW + CoordW;   // coefficient times coordinate
  localparam int unsigned SumW   = ProdW + 2;        // two products plus offset
  localparam int unsigned QuotW  = SumW - FracW;     // integer part after shift
  localparam int unsigned CfgIdxW = 3;

  localparam logic signed [SumW-1:0] HalfLsb = SumW'(64'sh8000);
  localparam logic signed [QuotW-1:0] SatMax = QuotW'(64'sd32767);
  localparam logic signed [QuotW-1:0] SatMin = QuotW'(-64'sd32768);

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoefW-1:0]  coef_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_X_FROM_X = 3'd0,
    CFG_X_FROM_Y = 3'd1,
    CFG_X_OFFSET = 3'd2,
    CFG_Y_FROM_X = 3'd3,
    CFG_Y_FROM_Y = 3'd4,
    CFG_Y_OFFSET = 3'd5
  } cfg_idx_e;

  localparam coef_t ResetUnity = CoefW'(32'sh0001_0000);
  localparam coef_t ResetZero  = '0;

  typedef struct packed {
    coef_t x_from_x;
    coef_t x_from_y;
    coef_t x_offset;
    coef_t y_from_x;
    coef_t y_from_y;
    coef_t y_offset;
  } cfg_t;

  typedef struct packed {
    coord_t left_in;
    coord_t top_in;
    coord_t right_in;
    coord_t bottom_in;
  } in_beat_t;

  typedef struct packed {
    coord_t out_left;
    coord_t out_top;
    coord_t out_right;
    coord_t out_bottom;
    logic   clipped;
  } out_beat_t;

  // per-stage load enables, driven by the top-level pipeline control
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
  } pipe_en_t;

  // rounded bounds of one axis
  typedef struct packed {
    coord_t lo;
    coord_t hi;
    logic   clip;
  } axis_res_t;

  // Round half up (add half, arithmetic shift) and saturate to 16 bits.
  function automatic coord_t round_sat(input sum_t v, output logic clip);
    sum_t                     t;
    logic signed [QuotW-1:0]  q;
    t = v + HalfLsb;
    q = t[SumW-1:FracW];
    clip = 1'b0;
    if (q > SatMax) begin
      q    = SatMax;
      clip = 1'b1;
    end else if (q < SatMin) begin
      q    = SatMin;
      clip = 1'b1;
    end
    return q[CoordW-1:0];
  endfunction

endpackage

// ===== rtl/core/arb_cfg.sv =====
// Configuration register file: six Q15.16 matrix entries written by index.
// Depends on arb_pkg.
module arb_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [arb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [arb_pkg::CoefW-1:0]    cfg_wdata_i,
  output arb_pkg::cfg_t                cfg_o
);

  arb_pkg::cfg_t cfg_q, cfg_d;

  // decode the write; unknown indexes leave everything as it is
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (arb_pkg::cfg_idx_e'(cfg_idx_i))
        arb_pkg::CFG_X_FROM_X: cfg_d.x_from_x = cfg_wdata_i;
        arb_pkg::CFG_X_FROM_Y: cfg_d.x_from_y = cfg_wdata_i;
        arb_pkg::CFG_X_OFFSET: cfg_d.x_offset = cfg_wdata_i;
        arb_pkg::CFG_Y_FROM_X: cfg_d.y_from_x = cfg_wdata_i;
        arb_pkg::CFG_Y_FROM_Y: cfg_d.y_from_y = cfg_wdata_i;
        arb_pkg::CFG_Y_OFFSET: cfg_d.y_offset = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // identity map out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_from_x <= arb_pkg::ResetUnity;
      cfg_q.x_from_y <= arb_pkg::ResetZero;
      cfg_q.x_offset <= arb_pkg::ResetZero;
      cfg_q.y_from_x <= arb_pkg::ResetZero;
      cfg_q.y_from_y <= arb_pkg::ResetUnity;
      cfg_q.y_offset <= arb_pkg::ResetZero;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/arb_axis.sv =====
// Datapath of one output axis: products, min/max sums, rounding and saturation.
// Depends on arb_pkg; stage enables come from the top-level pipeline control.
module arb_axis (
  input  logic              clk_i,
  input  arb_pkg::pipe_en_t en_i,
  input  arb_pkg::coef_t    coef_u_i,   // coefficient of input x
  input  arb_pkg::coef_t    coef_w_i,   // coefficient of input y
  input  arb_pkg::coef_t    offset_i,
  input  arb_pkg::coord_t   u0_i,       // left
  input  arb_pkg::coord_t   u1_i,       // right
  input  arb_pkg::coord_t   w0_i,       // top
  input  arb_pkg::coord_t   w1_i,       // bottom
  output arb_pkg::axis_res_t res_o
);

  arb_pkg::prod_t pu0_q, pu1_q, pw0_q, pw1_q;
  arb_pkg::prod_t pu0_d, pu1_d, pw0_d, pw1_d;
  arb_pkg::coef_t off_q;
  arb_pkg::sum_t  lo_q, hi_q, lo_d, hi_d;
  arb_pkg::prod_t umin, umax, wmin, wmax;
  arb_pkg::axis_res_t res_q, res_d;
  logic clip_lo, clip_hi;

  // stage 1: four products, one per edge coordinate
  assign pu0_d = arb_pkg::ProdW'(coef_u_i) * arb_pkg::ProdW'(u0_i);
  assign pu1_d = arb_pkg::ProdW'(coef_u_i) * arb_pkg::ProdW'(u1_i);
  assign pw0_d = arb_pkg::ProdW'(coef_w_i) * arb_pkg::ProdW'(w0_i);
  assign pw1_d = arb_pkg::ProdW'(coef_w_i) * arb_pkg::ProdW'(w1_i);

  always_ff @(posedge clk_i) begin
    if (en_i.s1_en) begin
      pu0_q <= pu0_d;
      pu1_q <= pu1_d;
      pw0_q <= pw0_d;
      pw1_q <= pw1_d;
      off_q <= offset_i;
    end
  end

  // stage 2: the map is separable, so the corner extremes are the sums of
  // the per-term extremes plus the offset
  always_comb begin
    umin = (pu0_q < pu1_q) ? pu0_q : pu1_q;
    umax = (pu0_q < pu1_q) ? pu1_q : pu0_q;
    wmin = (pw0_q < pw1_q) ? pw0_q : pw1_q;
    wmax = (pw0_q < pw1_q) ? pw1_q : pw0_q;
    lo_d = arb_pkg::SumW'(umin) + arb_pkg::SumW'(wmin) + arb_pkg::SumW'(off_q);
    hi_d = arb_pkg::SumW'(umax) + arb_pkg::SumW'(wmax) + arb_pkg::SumW'(off_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2_en) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // stage 3: round half up and clamp into the result register
  always_comb begin
    res_d.lo   = arb_pkg::round_sat(lo_q, clip_lo);
    res_d.hi   = arb_pkg::round_sat(hi_q, clip_hi);
    res_d.clip = clip_lo | clip_hi;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3_en) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/core/affine_rect_bounds.sv =====
// Bounding box of an integer rectangle under a Q15.16 2x3 affine map.
// An accepted input beat passes the input register, product register, sum register
// and rounded result register on its way to the result beat.
// Throughput: one beat per cycle; each stage advances when the one after it is
// free, so only a stalled result holds items back. Depends on arb_pkg.
// Reset clears all valid bits and loads the identity matrix; data regs are not reset.
module affine_rect_bounds (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [arb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [arb_pkg::CoefW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  arb_pkg::in_beat_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output arb_pkg::out_beat_t           out_data_o
);

  arb_pkg::cfg_t      cfg;
  arb_pkg::in_beat_t  in_q;
  arb_pkg::pipe_en_t  en;
  arb_pkg::axis_res_t x_res, y_res;
  logic v0_q, v1_q, v2_q, v3_q;
  logic rdy0, rdy1, rdy2, rdy3;

  arb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // a stage can take new data when empty or when its content moves on
  assign rdy3 = !v3_q || !out_stall_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign in_stall_o = !rdy0;

  assign en.s1_en = rdy1 && v0_q;
  assign en.s2_en = rdy2 && v1_q;
  assign en.s3_en = rdy3 && v2_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy0) begin
      in_q <= in_data_i;
    end
  end

  arb_axis u_axis_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .coef_u_i (cfg.x_from_x),
    .coef_w_i (cfg.x_from_y),
    .offset_i (cfg.x_offset),
    .u0_i     (in_q.left_in),
    .u1_i     (in_q.right_in),
    .w0_i     (in_q.top_in),
    .w1_i     (in_q.bottom_in),
    .res_o    (x_res)
  );

  arb_axis u_axis_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .coef_u_i (cfg.y_from_x),
    .coef_w_i (cfg.y_from_y),
    .offset_i (cfg.y_offset),
    .u0_i     (in_q.left_in),
    .u1_i     (in_q.right_in),
    .w0_i     (in_q.top_in),
    .w1_i     (in_q.bottom_in),
    .res_o    (y_res)
  );

  assign out_valid_o          = v3_q;
  assign out_data_o.out_left   = x_res.lo;
  assign out_data_o.out_right  = x_res.hi;
  assign out_data_o.out_top    = y_res.lo;
  assign out_data_o.out_bottom = y_res.hi;
  assign out_data_o.clipped    = x_res.clip | y_res.clip;

endmodule

// ===== rtl/core/arb_checker.sv =====
// Port-level checker for affine_rect_bounds, attached by the bind below.
// Depends on arb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module arb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input arb_pkg::out_beat_t  out_data_o
);

  logic out_held;
  logic box_ok;

  // result beat offered but blocked by the receiver
  assign out_held = out_valid_o && out_stall_i;

  // edges of the offered box are in order
  assign box_ok = (out_data_o.out_left <= out_data_o.out_right) &&
                  (out_data_o.out_top <= out_data_o.out_bottom);

  // a held result beat keeps its value
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_data_o))

  // the input side only backs up when the result beat is blocked
  `ASSERT_IMPLIES(a_stall_cause, clk_i, rst_ni, in_stall_o, out_held)

  // min edges never pass max edges, clamped or not
  `ASSERT_IMPLIES(a_box_order, clk_i, rst_ni, out_valid_o, box_ok)

endmodule

bind affine_rect_bounds arb_checker u_arb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== test/affine_rect_bounds_tb.sv =====
// Testbench for affine_rect_bounds: a directed plan of rectangles and matrix writes,
// then random phases under random Q15.16 matrices, scored against hand-set boxes or a local predictor.
// Depends on arb_pkg and the affine_rect_bounds RTL.
module affine_rect_bounds_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 200000;
  localparam int RandPhases  = 12;
  localparam int PhaseItems  = 79;
  localparam int MaxGap      = 17;
  localparam int DrainCycles = 8;
  localparam int LongHold    = 200;

  // register indexes past the last real register; writes there must be ignored
  localparam logic [arb_pkg::CfgIdxW-1:0] CfgSpareA = 3'd6;
  localparam logic [arb_pkg::CfgIdxW-1:0] CfgSpareB = 3'd7;

  typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_e;
  typedef enum int {MAT_WIDE, MAT_MILD, MAT_EDGE, MAT_SPARSE} mat_style_e;
  typedef enum int {RECT_NEAR, RECT_FULL, RECT_EDGE} rect_style_e;

  typedef struct {
    row_kind_e                   kind;
    logic [arb_pkg::CfgIdxW-1:0] idx;
    arb_pkg::coef_t              val;
    arb_pkg::in_beat_t           rect;
    bit                          known;
    arb_pkg::out_beat_t          want;
  } plan_row_t;

  logic                         clk;
  logic                         rst_ni    = 1'b0;
  logic                         cfg_we    = 1'b0;
  logic [arb_pkg::CfgIdxW-1:0]  cfg_idx   = '0;
  logic [arb_pkg::CoefW-1:0]    cfg_wdata = '0;
  logic                         in_valid  = 1'b0;
  arb_pkg::in_beat_t            in_data   = '0;
  logic                         out_stall = 1'b0;
  logic                         in_stall;
  logic                         out_valid;
  arb_pkg::out_beat_t           out_data;

  arb_pkg::cfg_t      mat;            // matrix as the block should hold it
  arb_pkg::out_beat_t bounds_due[$];  // predicted boxes in issue order
  plan_row_t          plan[$];
  int fail_count  = 0;
  int sent_count  = 0;
  int box_count   = 0;
  int clip_count  = 0;
  int send_gap_max = 0;
  int sink_gap_max = 0;
  int hold_cycles  = 0;

  affine_rect_bounds dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Half-up rounding of a Q.16 value, clamped to 16-bit signed
  function automatic arb_pkg::coord_t round_clamp(input longint v, inout bit hit);
    longint q;
    q = (v + 64'sd32768) >>> 16;
    if (q > 32767) begin
      q   = 32767;
      hit = 1'b1;
    end else if (q < -32768) begin
      q   = -32768;
      hit = 1'b1;
    end
    return arb_pkg::coord_t'(q);
  endfunction

  // Map all four corners, take per-axis min/max on exact values, then round
  function automatic arb_pkg::out_beat_t predict_bounds(input arb_pkg::in_beat_t r,
                                                        input arb_pkg::cfg_t m);
    longint xs[2];
    longint ys[2];
    longint mx, my, lo_x, hi_x, lo_y, hi_y;
    bit hit;
    arb_pkg::out_beat_t o;
    xs[0] = r.left_in;
    xs[1] = r.right_in;
    ys[0] = r.top_in;
    ys[1] = r.bottom_in;
    lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
    hit  = 1'b0;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        mx = longint'(m.x_from_x) * xs[j] + longint'(m.x_from_y) * ys[i] + longint'(m.x_offset);
        my = longint'(m.y_from_x) * xs[j] + longint'(m.y_from_y) * ys[i] + longint'(m.y_offset);
        if ((i == 0 && j == 0) || mx < lo_x) lo_x = mx;
        if ((i == 0 && j == 0) || mx > hi_x) hi_x = mx;
        if ((i == 0 && j == 0) || my < lo_y) lo_y = my;
        if ((i == 0 && j == 0) || my > hi_y) hi_y = my;
      end
    end
    o.out_left   = round_clamp(lo_x, hit);
    o.out_top    = round_clamp(lo_y, hit);
    o.out_right  = round_clamp(hi_x, hit);
    o.out_bottom = round_clamp(hi_y, hit);
    o.clipped    = hit;
    return o;
  endfunction

  function automatic arb_pkg::in_beat_t mk_rect(input int l, input int t, input int r,
                                                input int b);
    arb_pkg::in_beat_t v;
    v.left_in   = arb_pkg::coord_t'(l);
    v.top_in    = arb_pkg::coord_t'(t);
    v.right_in  = arb_pkg::coord_t'(r);
    v.bottom_in = arb_pkg::coord_t'(b);
    return v;
  endfunction

  function automatic arb_pkg::out_beat_t mk_box(input int l, input int t, input int r,
                                                input int b, input bit c);
    arb_pkg::out_beat_t v;
    v.out_left   = arb_pkg::coord_t'(l);
    v.out_top    = arb_pkg::coord_t'(t);
    v.out_right  = arb_pkg::coord_t'(r);
    v.out_bottom = arb_pkg::coord_t'(b);
    v.clipped    = c;
    return v;
  endfunction

  function automatic void add_item(input arb_pkg::in_beat_t r, input bit known,
                                   input arb_pkg::out_beat_t want);
    plan_row_t row;
    row.kind  = ROW_ITEM;
    row.idx   = '0;
    row.val   = '0;
    row.rect  = r;
    row.known = known;
    row.want  = want;
    plan.push_back(row);
  endfunction

  function automatic void add_write(input logic [arb_pkg::CfgIdxW-1:0] idx,
                                    input arb_pkg::coef_t val);
    plan_row_t row;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.val   = val;
    row.rect  = '0;
    row.known = 1'b0;
    row.want  = '0;
    plan.push_back(row);
  endfunction

  // Random coefficient or offset in the flavor of the phase
  function automatic arb_pkg::coef_t pick_coef(input mat_style_e style, input bit is_offset);
    case (style)
      MAT_WIDE: return arb_pkg::coef_t'($urandom);
      MAT_MILD: begin
        if (is_offset) return arb_pkg::coef_t'(int'($urandom_range(0, 262144000)) - 131072000);
        return arb_pkg::coef_t'(int'($urandom_range(0, 524288)) - 262144);
      end
      MAT_EDGE: begin
        case ($urandom_range(0, 7))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'h0001_0000;
          4:       return 32'hFFFF_0000;
          5:       return 32'h0000_8000;
          6:       return 32'hFFFF_8000;
          default: return arb_pkg::coef_t'($urandom);
        endcase
      end
      default: begin
        // axis swaps, flips and simple scales with offsets of up to 64 pixels either way
        if (is_offset) return arb_pkg::coef_t'(int'($urandom_range(0, 8388608)) - 4194304);
        case ($urandom_range(0, 5))
          0, 1:    return 32'h0000_0000;
          2:       return 32'h0001_0000;
          3:       return 32'hFFFF_0000;
          4:       return 32'h0000_8000;
          default: return 32'h0002_0000;
        endcase
      end
    endcase
  endfunction

  function automatic arb_pkg::coord_t pick_coord(input rect_style_e style);
    case (style)
      RECT_NEAR: return arb_pkg::coord_t'(int'($urandom_range(0, 4000)) - 2000);
      RECT_FULL: return arb_pkg::coord_t'($urandom);
      default: begin
        case ($urandom_range(0, 5))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return 16'sh0000;
          3:       return 16'shFFFF;
          4:       return 16'sh0001;
          default: return arb_pkg::coord_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // Offer one rectangle after a random gap and hold it until the block takes it
  task automatic push_rect(input arb_pkg::in_beat_t r, input bit known,
                           input arb_pkg::out_beat_t want);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    cfg_we <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    bounds_due.push_back(known ? want : predict_bounds(r, mat));
    sent_count++;
  endtask

  // Stop offering and let the pipeline empty out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (bounds_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [arb_pkg::CfgIdxW-1:0] idx,
                           input arb_pkg::coef_t val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      arb_pkg::CFG_X_FROM_X: mat.x_from_x = val;
      arb_pkg::CFG_X_FROM_Y: mat.x_from_y = val;
      arb_pkg::CFG_X_OFFSET: mat.x_offset = val;
      arb_pkg::CFG_Y_FROM_X: mat.y_from_x = val;
      arb_pkg::CFG_Y_FROM_Y: mat.y_from_y = val;
      arb_pkg::CFG_Y_OFFSET: mat.y_offset = val;
      default: ;
    endcase
  endtask

  task automatic flag_field(input string name, input logic signed [15:0] want,
                            input logic signed [15:0] got);
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    fail_count++;
  endtask

  // Result side: score every beat taken at a clock edge
  always @(posedge clk) begin : box_check
    arb_pkg::out_beat_t want;
    if (rst_ni && out_valid && !out_stall) begin
      box_count++;
      if (out_data.clipped === 1'b1) clip_count++;
      if (bounds_due.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, out_data);
        fail_count++;
      end else begin
        want = bounds_due.pop_front();
        if (out_data.out_left !== want.out_left)
          flag_field("out_left", want.out_left, out_data.out_left);
        if (out_data.out_top !== want.out_top)
          flag_field("out_top", want.out_top, out_data.out_top);
        if (out_data.out_right !== want.out_right)
          flag_field("out_right", want.out_right, out_data.out_right);
        if (out_data.out_bottom !== want.out_bottom)
          flag_field("out_bottom", want.out_bottom, out_data.out_bottom);
        if (out_data.clipped !== want.clipped)
          flag_field("clipped", {15'b0, want.clipped}, {15'b0, out_data.clipped});
      end
    end
  end

  // Receiver: random stall before each beat, plus an occasional long hold-off
  initial begin : box_sink
    int n;
    wait (rst_ni);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = $urandom_range(0, sink_gap_max);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        for (int c = 0; c < n; c++) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles, %0d boxes still due", $time, CycleLimit,
             bounds_due.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    bit busy;
    mat_style_e style;
    rect_style_e rs;
    arb_pkg::in_beat_t r;
    mat = {arb_pkg::ResetUnity, arb_pkg::ResetZero, arb_pkg::ResetZero,
           arb_pkg::ResetZero, arb_pkg::ResetUnity, arb_pkg::ResetZero};
    send_gap_max = 3;
    sink_gap_max = 2;

    // identity after reset: output is the rectangle with edges put in order
    add_item(mk_rect(0, 0, 0, 0), 1'b1, mk_box(0, 0, 0, 0, 1'b0));
    add_item(mk_rect(-32768, -32768, 32767, 32767), 1'b1,
             mk_box(-32768, -32768, 32767, 32767, 1'b0));
    add_item(mk_rect(100, -50, -20, -300), 1'b1, mk_box(-20, -300, 100, -50, 1'b0));
    add_item(mk_rect(32767, 32767, -32768, -32768), 1'b1,
             mk_box(-32768, -32768, 32767, 32767, 1'b0));
    // writes past the register file leave the identity in place
    add_write(CfgSpareA, 32'h0000_0000);
    add_write(CfgSpareB, 32'h1234_5678);
    add_item(mk_rect(1, 2, 3, 4), 1'b1, mk_box(1, 2, 3, 4, 1'b0));
    // offset pushes x just past the top bound
    add_write(arb_pkg::CFG_X_OFFSET, 32'h7FFF_0000);
    add_item(mk_rect(0, 0, 0, 0), 1'b1, mk_box(32767, 0, 32767, 0, 1'b0));
    add_item(mk_rect(1, -5, 2, 5), 1'b1, mk_box(32767, -5, 32767, 5, 1'b1));
    // and just past the bottom bound
    add_write(arb_pkg::CFG_X_OFFSET, 32'h8000_0000);
    add_item(mk_rect(0, 0, 0, 0), 1'b1, mk_box(-32768, 0, -32768, 0, 1'b0));
    add_item(mk_rect(-1, 0, 3, 0), 1'b1, mk_box(-32768, 0, -32765, 0, 1'b1));
    // exact halves round up, one LSB under a half rounds down
    add_write(arb_pkg::CFG_X_OFFSET, 32'h0000_8000);
    add_write(arb_pkg::CFG_Y_OFFSET, 32'hFFFF_8000);
    add_item(mk_rect(0, 0, 0, 0), 1'b1, mk_box(1, 0, 1, 0, 1'b0));
    add_write(arb_pkg::CFG_X_OFFSET, 32'h0000_7FFF);
    add_write(arb_pkg::CFG_Y_OFFSET, 32'hFFFE_8000);
    add_item(mk_rect(0, 0, 0, 0), 1'b1, mk_box(0, -1, 0, -1, 1'b0));
    // every register at an extreme
    add_write(arb_pkg::CFG_X_FROM_X, 32'h7FFF_FFFF);
    add_write(arb_pkg::CFG_X_FROM_Y, 32'h8000_0000);
    add_write(arb_pkg::CFG_X_OFFSET, 32'h7FFF_FFFF);
    add_write(arb_pkg::CFG_Y_FROM_X, 32'h8000_0000);
    add_write(arb_pkg::CFG_Y_FROM_Y, 32'h7FFF_FFFF);
    add_write(arb_pkg::CFG_Y_OFFSET, 32'h8000_0000);
    add_item(mk_rect(0, 0, 0, 0), 1'b1, mk_box(32767, -32768, 32767, -32768, 1'b1));
    add_item(mk_rect(-32768, -32768, 32767, 32767), 1'b0, '0);
    add_item(mk_rect(32767, -32768, -32768, 32767), 1'b0, '0);
    // quarter turn: X = -y, Y = x
    add_write(arb_pkg::CFG_X_FROM_X, 32'h0000_0000);
    add_write(arb_pkg::CFG_X_FROM_Y, 32'hFFFF_0000);
    add_write(arb_pkg::CFG_X_OFFSET, 32'h0000_0000);
    add_write(arb_pkg::CFG_Y_FROM_X, 32'h0001_0000);
    add_write(arb_pkg::CFG_Y_FROM_Y, 32'h0000_0000);
    add_write(arb_pkg::CFG_Y_OFFSET, 32'h0000_0000);
    add_item(mk_rect(10, 20, 30, 40), 1'b1, mk_box(-40, 10, -20, 30, 1'b0));
    add_item(mk_rect(-7, 3, 12, -9), 1'b0, '0);
    // thirty degree turn with fractional offsets
    add_write(arb_pkg::CFG_X_FROM_X, 32'h0000_DDB4);
    add_write(arb_pkg::CFG_X_FROM_Y, 32'hFFFF_8000);
    add_write(arb_pkg::CFG_X_OFFSET, 32'h0012_3456);
    add_write(arb_pkg::CFG_Y_FROM_X, 32'h0000_8000);
    add_write(arb_pkg::CFG_Y_FROM_Y, 32'h0000_DDB4);
    add_write(arb_pkg::CFG_Y_OFFSET, 32'hFFF0_4000);
    add_item(mk_rect(-100, -50, 200, 75), 1'b0, '0);
    add_item(mk_rect(0, 0, 1, 1), 1'b0, '0);

    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // directed plan: drain before any register write that follows items
    busy = 1'b0;
    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WRITE) begin
        if (busy) wait_idle();
        busy = 1'b0;
        write_reg(plan[k].idx, plan[k].val);
      end else begin
        push_rect(plan[k].rect, plan[k].known, plan[k].want);
        busy = 1'b1;
      end
    end

    // random phases, each under a fresh matrix and its own idling mix
    for (int ph = 0; ph < RandPhases; ph++) begin
      wait_idle();
      style = mat_style_e'(ph % 4);
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? CfgSpareA : CfgSpareB, arb_pkg::coef_t'($urandom));
      write_reg(arb_pkg::CFG_X_FROM_X, pick_coef(style, 1'b0));
      write_reg(arb_pkg::CFG_X_FROM_Y, pick_coef(style, 1'b0));
      write_reg(arb_pkg::CFG_X_OFFSET, pick_coef(style, 1'b1));
      write_reg(arb_pkg::CFG_Y_FROM_X, pick_coef(style, 1'b0));
      write_reg(arb_pkg::CFG_Y_FROM_Y, pick_coef(style, 1'b0));
      write_reg(arb_pkg::CFG_Y_OFFSET, pick_coef(style, 1'b1));
      case ($urandom_range(0, 2))
        0:       send_gap_max = 0;
        1:       send_gap_max = MaxGap;
        default: send_gap_max = 4;
      endcase
      case ($urandom_range(0, 2))
        0:       sink_gap_max = 0;
        1:       sink_gap_max = MaxGap;
        default: sink_gap_max = 4;
      endcase
      // back-to-back beats into a receiver that holds off: the block must fill and stall
      if (ph == 3 || ph == 9) begin
        send_gap_max = 0;
        hold_cycles  = LongHold;
      end
      repeat (PhaseItems) begin
        case ($urandom_range(0, 9))
          0, 1:    rs = RECT_FULL;
          2:       rs = RECT_EDGE;
          default: rs = RECT_NEAR;
        endcase
        r.left_in   = pick_coord(rs);
        r.top_in    = pick_coord(rs);
        r.right_in  = pick_coord(rs);
        r.bottom_in = pick_coord(rs);
        push_rect(r, 1'b0, '0);
      end
    end

    wait_idle();
    $display("Sent %0d rectangles over a directed plan and %0d random matrix phases;",
             sent_count, RandPhases);
    $display("checked %0d bounding boxes, %0d of them saturated.", box_count, clip_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
